// ===== hdl/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared request types, phase and result-kind codes, and byte constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SYSLEN   = 4'd4,
    PH_SYSSKIP  = 4'd5,
    PH_METATYPE = 4'd6,
    PH_METALEN  = 4'd7,
    PH_METAPAY  = 4'd8,
    PH_STOPPED  = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    KIND_CHANNEL  = 3'd0,
    KIND_META_HDR = 3'd1,
    KIND_META_PAY = 3'd2,
    KIND_REJECTED = 3'd3,
    KIND_SYSEX    = 3'd4
  } kind_e;

  localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;
  localparam logic [7:0] STATUS_PITCH    = 8'hE0;
  localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE   = 8'hF7;
  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] META_END_TRACK  = 8'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_req_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] delta_time;
    logic [7:0]  status_value;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  data_count;
    logic [7:0]  meta_kind;
    logic [31:0] meta_length;
    logic [7:0]  payload_byte;
    logic        event_done;
    logic        end_of_track;
  } out_req_t;

endpackage

`default_nettype wire

// ===== hdl/mtep_core.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Holds the parse state and turns one accepted byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire mtep_pkg::in_req_t req_i,
  output logic                   res_valid_o,
  output mtep_pkg::out_req_t     res_o
);

  mtep_pkg::phase_e phase_q, phase_d, ph;
  logic [31:0] dacc_q, dacc_d, dacc;
  logic [31:0] len_q, len_d, len;
  logic [7:0]  status_q, status_d, status;
  logic [7:0]  held_q, held_d, held;
  logic [7:0]  mkind_q, mkind_d, mkind;
  logic [7:0]  b;
  logic        more;
  logic [31:0] dacc_shift;
  logic [31:0] len_shift;
  logic [31:0] len_dec;
  logic        meta_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mtep_pkg::PH_DELTA;
      dacc_q   <= '0;
      len_q    <= '0;
      status_q <= '0;
      held_q   <= '0;
      mkind_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      dacc_q   <= dacc_d;
      len_q    <= len_d;
      status_q <= status_d;
      held_q   <= held_d;
      mkind_q  <= mkind_d;
    end
  end

  always_comb begin
    b          = req_i.data_byte;
    more       = b[7];
    ph         = req_i.track_start ? mtep_pkg::PH_DELTA : phase_q;
    dacc       = req_i.track_start ? 32'd0 : dacc_q;
    len        = req_i.track_start ? 32'd0 : len_q;
    status     = req_i.track_start ? 8'd0 : status_q;
    held       = req_i.track_start ? 8'd0 : held_q;
    mkind      = req_i.track_start ? 8'd0 : mkind_q;
    dacc_shift = {dacc[24:0], b[6:0]};
    len_shift  = {len[24:0], b[6:0]};
    len_dec    = len - 32'd1;
    meta_end   = (mkind == mtep_pkg::META_END_TRACK);

    phase_d  = phase_q;
    dacc_d   = dacc_q;
    len_d    = len_q;
    status_d = status_q;
    held_d   = held_q;
    mkind_d  = mkind_q;

    res_valid_o      = 1'b0;
    res_o            = '0;
    res_o.delta_time = dacc;

    if (take_i) begin
      phase_d  = ph;
      dacc_d   = dacc;
      len_d    = len;
      status_d = status;
      held_d   = held;
      mkind_d  = mkind;
      unique case (ph)
        mtep_pkg::PH_DELTA: begin
          dacc_d = dacc_shift;
          if (!more) begin
            phase_d = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (more && b < mtep_pkg::STATUS_SYSEX) begin
            status_d = b;
            phase_d  = mtep_pkg::PH_DATA1;
          end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
            status_d = b;
            len_d    = '0;
            phase_d  = mtep_pkg::PH_SYSLEN;
          end else if (b == mtep_pkg::STATUS_META) begin
            status_d = b;
            phase_d  = mtep_pkg::PH_METATYPE;
          end else begin
            res_valid_o        = 1'b1;
            res_o.kind         = mtep_pkg::KIND_REJECTED;
            res_o.status_value = b;
            res_o.event_done   = 1'b1;
            phase_d            = mtep_pkg::PH_DELTA;
            dacc_d             = '0;
          end
        end
        mtep_pkg::PH_DATA1: begin
          if (status >= mtep_pkg::STATUS_PROGRAM && status < mtep_pkg::STATUS_PITCH) begin
            res_valid_o        = 1'b1;
            res_o.kind         = mtep_pkg::KIND_CHANNEL;
            res_o.status_value = status;
            res_o.first_data   = b;
            res_o.data_count   = 2'd1;
            res_o.event_done   = 1'b1;
            phase_d            = mtep_pkg::PH_DELTA;
            dacc_d             = '0;
          end else begin
            held_d  = b;
            phase_d = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: begin
          res_valid_o        = 1'b1;
          res_o.kind         = mtep_pkg::KIND_CHANNEL;
          res_o.status_value = status;
          res_o.first_data   = held;
          res_o.second_data  = b;
          res_o.data_count   = 2'd2;
          res_o.event_done   = 1'b1;
          phase_d            = mtep_pkg::PH_DELTA;
          dacc_d             = '0;
        end
        mtep_pkg::PH_SYSLEN: begin
          len_d = len_shift;
          if (!more) begin
            if (len_shift != 32'd0) begin
              phase_d = mtep_pkg::PH_SYSSKIP;
            end else begin
              res_valid_o        = 1'b1;
              res_o.kind         = mtep_pkg::KIND_SYSEX;
              res_o.status_value = status;
              res_o.event_done   = 1'b1;
              phase_d            = mtep_pkg::PH_DELTA;
              dacc_d             = '0;
            end
          end
        end
        mtep_pkg::PH_SYSSKIP: begin
          len_d = len_dec;
          if (len_dec == 32'd0) begin
            res_valid_o        = 1'b1;
            res_o.kind         = mtep_pkg::KIND_SYSEX;
            res_o.status_value = status;
            res_o.event_done   = 1'b1;
            phase_d            = mtep_pkg::PH_DELTA;
            dacc_d             = '0;
          end
        end
        mtep_pkg::PH_METATYPE: begin
          mkind_d = b;
          len_d   = '0;
          phase_d = mtep_pkg::PH_METALEN;
        end
        mtep_pkg::PH_METALEN: begin
          len_d = len_shift;
          if (!more) begin
            res_valid_o        = 1'b1;
            res_o.kind         = mtep_pkg::KIND_META_HDR;
            res_o.status_value = mtep_pkg::STATUS_META;
            res_o.meta_kind    = mkind;
            res_o.meta_length  = len_shift;
            if (len_shift == 32'd0) begin
              res_o.event_done   = 1'b1;
              res_o.end_of_track = meta_end;
              phase_d = meta_end ? mtep_pkg::PH_STOPPED : mtep_pkg::PH_DELTA;
              dacc_d  = '0;
            end else begin
              phase_d = mtep_pkg::PH_METAPAY;
            end
          end
        end
        mtep_pkg::PH_METAPAY: begin
          res_valid_o        = 1'b1;
          res_o.kind         = mtep_pkg::KIND_META_PAY;
          res_o.status_value = mtep_pkg::STATUS_META;
          res_o.meta_kind    = mkind;
          res_o.payload_byte = b;
          len_d              = len_dec;
          if (len_dec == 32'd0) begin
            res_o.event_done   = 1'b1;
            res_o.end_of_track = meta_end;
            phase_d = meta_end ? mtep_pkg::PH_STOPPED : mtep_pkg::PH_DELTA;
            dacc_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mtep_out_skid.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser output stage
// Result register with one skid entry, so the input stall is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_out_skid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               res_valid_i,
  input  wire mtep_pkg::out_req_t res_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mtep_pkg::out_req_t      out_req_o
);

  logic               main_valid_q, main_valid_d;
  logic               skid_valid_q, skid_valid_d;
  mtep_pkg::out_req_t main_q, main_d;
  mtep_pkg::out_req_t skid_q, skid_d;
  logic               main_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  always_comb begin
    main_take    = main_valid_q && !out_stall_i;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (main_take) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!main_valid_q || main_take) begin
        main_d       = res_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (main_take) begin
      main_valid_d = 1'b0;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_req_o   = main_q;

endmodule

`default_nettype wire

// ===== hdl/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses track-chunk bytes into channel, sysex, meta and rejected-status results.
// ----------------------------------------------------------------------------
// The parser takes one track byte in every cycle while in_stall_o is low and
// produces at most one result per byte, registered before it reaches the output.
// The parse state updates in the same cycle the byte is accepted, and the
// result enters an output register backed by one skid entry, so the input
// stalls only after a result has waited behind a stalled output. Setting
// track_start with a byte restarts the parser before that byte is used.
`default_nettype none

module midi_track_event_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mtep_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mtep_pkg::out_req_t      out_req_o
);

  logic               take;
  logic               res_valid;
  mtep_pkg::out_req_t res;

  assign take = in_valid_i && !in_stall_o;

  mtep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtep_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  a_skid_needs_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry held without a result in the output register");

  a_eot_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.end_of_track) |-> out_req_o.event_done)
    else $error("end of track reported on a result that does not finish its event");

  a_chan_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.kind == mtep_pkg::KIND_CHANNEL)
      |-> (out_req_o.data_count == 2'd1 || out_req_o.data_count == 2'd2))
    else $error("channel message with a bad data count");

  a_no_result_without_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !take) |=> !out_valid_o)
    else $error("result appeared without an accepted byte");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Drives track bytes through the parser and checks every result against a
// cycle-free predictor. It starts with a short directed table (channel,
// program, rejected, unknown, overlong delta, empty sysex, end-of-track,
// ignored byte) and then sends random events, mostly well formed, with
// random idling on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtep_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    in_req_t  req;
    bit       typed;
    out_req_t want;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  out_req_t out_req;

  bit       idle_on    = 1'b1;
  bit       hold_req   = 1'b0;
  bit       need_start = 1'b0;
  int       mismatches = 0;
  int       idle_cycles = 0;

  out_req_t result_q[$];
  in_req_t  burst_q[$];
  dir_row_t dir_q[$];

  // Predictor state.
  phase_e      ph;
  logic [31:0] dacc;
  logic [31:0] lcnt;
  logic [7:0]  cur_st;
  logic [7:0]  held;
  logic [7:0]  cur_mk;

  midi_track_event_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic parse_byte(input in_req_t req, output bit has, output out_req_t res);
    logic [7:0] b;
    b = req.data_byte;
    has = 1'b0;
    res = '0;
    if (req.track_start) begin
      ph = PH_DELTA;
      dacc = '0;
      lcnt = '0;
      cur_st = '0;
      held = '0;
      cur_mk = '0;
    end
    case (ph)
      PH_DELTA: begin
        dacc = {dacc[24:0], b[6:0]};
        if (!b[7]) ph = PH_STATUS;
      end
      PH_STATUS: begin
        if (b[7] && b < STATUS_SYSEX) begin
          cur_st = b;
          ph = PH_DATA1;
        end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
          cur_st = b;
          lcnt = '0;
          ph = PH_SYSLEN;
        end else if (b == STATUS_META) begin
          cur_st = b;
          ph = PH_METATYPE;
        end else begin
          has = 1'b1;
          res.kind = KIND_REJECTED;
          res.status_value = b;
          res.event_done = 1'b1;
        end
      end
      PH_DATA1: begin
        if (cur_st >= STATUS_PROGRAM && cur_st < STATUS_PITCH) begin
          has = 1'b1;
          res.kind = KIND_CHANNEL;
          res.status_value = cur_st;
          res.first_data = b;
          res.data_count = 2'd1;
          res.event_done = 1'b1;
        end else begin
          held = b;
          ph = PH_DATA2;
        end
      end
      PH_DATA2: begin
        has = 1'b1;
        res.kind = KIND_CHANNEL;
        res.status_value = cur_st;
        res.first_data = held;
        res.second_data = b;
        res.data_count = 2'd2;
        res.event_done = 1'b1;
      end
      PH_SYSLEN: begin
        lcnt = {lcnt[24:0], b[6:0]};
        if (!b[7]) begin
          if (lcnt != 0) begin
            ph = PH_SYSSKIP;
          end else begin
            has = 1'b1;
            res.kind = KIND_SYSEX;
            res.status_value = cur_st;
            res.event_done = 1'b1;
          end
        end
      end
      PH_SYSSKIP: begin
        lcnt = lcnt - 32'd1;
        if (lcnt == 0) begin
          has = 1'b1;
          res.kind = KIND_SYSEX;
          res.status_value = cur_st;
          res.event_done = 1'b1;
        end
      end
      PH_METATYPE: begin
        cur_mk = b;
        lcnt = '0;
        ph = PH_METALEN;
      end
      PH_METALEN: begin
        lcnt = {lcnt[24:0], b[6:0]};
        if (!b[7]) begin
          has = 1'b1;
          res.kind = KIND_META_HDR;
          res.status_value = STATUS_META;
          res.meta_kind = cur_mk;
          res.meta_length = lcnt;
          if (lcnt == 0) res.event_done = 1'b1;
          else ph = PH_METAPAY;
        end
      end
      PH_METAPAY: begin
        has = 1'b1;
        res.kind = KIND_META_PAY;
        res.status_value = STATUS_META;
        res.meta_kind = cur_mk;
        res.payload_byte = b;
        lcnt = lcnt - 32'd1;
        if (lcnt == 0) res.event_done = 1'b1;
      end
      default: begin
      end
    endcase
    if (has) res.delta_time = dacc;
    if (has && res.event_done) begin
      if ((res.kind == KIND_META_HDR || res.kind == KIND_META_PAY) &&
          cur_mk == META_END_TRACK) begin
        res.end_of_track = 1'b1;
        ph = PH_STOPPED;
      end else begin
        ph = PH_DELTA;
      end
      dacc = '0;
    end
  endtask

  function automatic out_req_t make_result(kind_e k, logic [31:0] dt, logic [7:0] st,
                                           logic [7:0] d1, logic [7:0] d2, logic [1:0] cnt,
                                           logic [7:0] mk, logic [31:0] ml, logic eot);
    out_req_t r;
    r = '0;
    r.kind = k;
    r.delta_time = dt;
    r.status_value = st;
    r.first_data = d1;
    r.second_data = d2;
    r.data_count = cnt;
    r.meta_kind = mk;
    r.meta_length = ml;
    r.event_done = 1'b1;
    r.end_of_track = eot;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] b, logic ts = 1'b0, bit typed = 1'b0,
                                  out_req_t want = '0);
    dir_row_t row;
    row.req.data_byte = b;
    row.req.track_start = ts;
    row.typed = typed;
    row.want = want;
    dir_q.push_back(row);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    in_req_t r;
    r.data_byte = b;
    r.track_start = need_start;
    need_start = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic logic [7:0] data_value();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                       : 8'($urandom_range(0, 127));
  endfunction

  function automatic void put_delta();
    int groups;
    groups = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3);
    for (int i = groups - 1; i >= 0; i--) put_byte({i != 0, 7'($urandom_range(0, 127))});
  endfunction

  function automatic void put_length(int len);
    case ($urandom_range(0, 7))
      0: put_byte(8'h80);
      // The top group only sets bits above 31, so the value wraps back to len.
      1: begin
        put_byte(8'hF0);
        repeat (3) put_byte(8'h80);
      end
      default: begin
      end
    endcase
    put_byte(8'(len));
  endfunction

  task automatic push_byte(input in_req_t req, input bit typed, input out_req_t want);
    bit       has;
    out_req_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(req, has, res);
    if (typed) result_q.push_back(want);
    else if (has) result_q.push_back(res);
  endtask

  task automatic gen_event(output int counted);
    int         pick;
    int         len;
    logic [7:0] st;
    logic [7:0] mk;
    bit         stop;
    burst_q.delete();
    stop = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_delta();
      if (pick < 50) begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        put_byte(st);
        put_byte(data_value());
        if (!(st >= STATUS_PROGRAM && st < STATUS_PITCH)) put_byte(data_value());
      end else if (pick < 60) begin
        put_byte($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE);
        len = $urandom_range(0, 6);
        put_length(len);
        repeat (len) put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        mk = ($urandom_range(0, 9) == 0) ? META_END_TRACK : 8'($urandom_range(0, 255));
        len = $urandom_range(0, 5);
        put_byte(STATUS_META);
        put_byte(mk);
        put_length(len);
        repeat (len) put_byte(8'($urandom_range(0, 255)));
        stop = (mk == META_END_TRACK);
      end else if (pick < 95) begin
        if ($urandom_range(0, 1)) begin
          st = 8'($urandom_range(0, 8'h7F));
        end else begin
          st = 8'($urandom_range(8'hF1, 8'hFE));
          if (st == STATUS_ESCAPE) st = st + 8'd1;
        end
        put_byte(st);
      end else begin
        // The event is cut short and the next byte restarts the track.
        put_byte(8'($urandom_range(8'h80, 8'hFF)));
        if ($urandom_range(0, 1)) put_byte(data_value());
      end
    end
    counted = burst_q.size();
    if (stop) repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
    if (pick < 4 || pick >= 95 || stop) need_start = 1'b1;
    foreach (burst_q[i]) push_byte(burst_q[i], 1'b0, '0);
  endtask

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    flag_error($sformatf("%s: expected %h, got %h", name, want, got));
  endtask

  task automatic check_result(input out_req_t got);
    out_req_t want;
    if (result_q.size() == 0) begin
      flag_error($sformatf("result with none expected: kind %0d status %h",
                           got.kind, got.status_value));
      return;
    end
    want = result_q.pop_front();
    if (got.kind !== want.kind) flag_field("kind", 32'(want.kind), 32'(got.kind));
    if (got.delta_time !== want.delta_time)
      flag_field("delta_time", want.delta_time, got.delta_time);
    if (got.status_value !== want.status_value)
      flag_field("status_value", 32'(want.status_value), 32'(got.status_value));
    if (got.first_data !== want.first_data)
      flag_field("first_data", 32'(want.first_data), 32'(got.first_data));
    if (got.second_data !== want.second_data)
      flag_field("second_data", 32'(want.second_data), 32'(got.second_data));
    if (got.data_count !== want.data_count)
      flag_field("data_count", 32'(want.data_count), 32'(got.data_count));
    if (got.meta_kind !== want.meta_kind)
      flag_field("meta_kind", 32'(want.meta_kind), 32'(got.meta_kind));
    if (got.meta_length !== want.meta_length)
      flag_field("meta_length", want.meta_length, got.meta_length);
    if (got.payload_byte !== want.payload_byte)
      flag_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    if (got.event_done !== want.event_done)
      flag_field("event_done", 32'(want.event_done), 32'(got.event_done));
    if (got.end_of_track !== want.end_of_track)
      flag_field("end_of_track", 32'(want.end_of_track), 32'(got.end_of_track));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_req);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("midi_track_event_parser: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int sent;
    int n;

    add_row(8'h00, 1'b1);
    add_row(8'hEF);
    add_row(8'h00);
    add_row(8'h7F, 1'b0, 1'b1, make_result(KIND_CHANNEL, 32'd0, 8'hEF, 8'h00, 8'h7F, 2'd2,
                                           8'h00, 32'd0, 1'b0));
    add_row(8'h7F);
    add_row(8'hC5);
    add_row(8'hFF, 1'b0, 1'b1, make_result(KIND_CHANNEL, 32'h7F, 8'hC5, 8'hFF, 8'h00, 2'd1,
                                           8'h00, 32'd0, 1'b0));
    add_row(8'h00);
    add_row(8'h45, 1'b0, 1'b1, make_result(KIND_REJECTED, 32'd0, 8'h45, 8'h00, 8'h00, 2'd0,
                                           8'h00, 32'd0, 1'b0));
    add_row(8'h81);
    add_row(8'h00);
    add_row(8'hF3, 1'b0, 1'b1, make_result(KIND_REJECTED, 32'h80, 8'hF3, 8'h00, 8'h00, 2'd0,
                                           8'h00, 32'd0, 1'b0));
    repeat (5) add_row(8'hFF);
    add_row(8'h7F);
    add_row(STATUS_ESCAPE);
    add_row(8'h00, 1'b0, 1'b1, make_result(KIND_SYSEX, 32'hFFFF_FFFF, STATUS_ESCAPE, 8'h00,
                                           8'h00, 2'd0, 8'h00, 32'd0, 1'b0));
    add_row(8'h00);
    add_row(STATUS_META);
    add_row(META_END_TRACK);
    add_row(8'h00, 1'b0, 1'b1, make_result(KIND_META_HDR, 32'd0, STATUS_META, 8'h00, 8'h00,
                                           2'd0, META_END_TRACK, 32'd0, 1'b1));
    add_row(8'h90);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_q[i]) push_byte(dir_q[i].req, dir_q[i].typed, dir_q[i].want);

    need_start = 1'b1;
    sent = 0;
    while (sent < 300) begin
      gen_event(n);
      sent += n;
    end
    hold_req = 1'b1;
    while (sent < 400) begin
      gen_event(n);
      sent += n;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    while (sent < 600) begin
      gen_event(n);
      sent += n;
    end
    idle_on = 1'b0;
    while (sent < 700) begin
      gen_event(n);
      sent += n;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("midi_track_event_parser: match");
    end else begin
      $display("midi_track_event_parser: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mtep_pkg.sv
hdl/mtep_core.sv
hdl/mtep_out_skid.sv
hdl/midi_track_event_parser.sv
test/tb_top.sv
